// ===== rtl/rbe_pkg.sv =====
// Shared constants, codes and controller/datapath signal groups for the RLE byte stream encoder.
package rbe_pkg;

    // Block format limits
    localparam int LIT_MAX = 64;
    localparam int LIT_AW  = 6;
    localparam int LIT_CW  = 7;
    localparam int RUN_MIN = 3;
    localparam int RUN_MAX = 255 - LIT_MAX + RUN_MIN;

    localparam logic [7:0]        RUN_HDR_OFS  = 8'(LIT_MAX - RUN_MIN);
    localparam logic [7:0]        RUN_LAST_INC = 8'(RUN_MAX - 1);
    localparam logic [7:0]        RUN_START    = 8'(RUN_MIN);
    localparam logic [LIT_CW-1:0] LIT_FILL_AT  = LIT_CW'(LIT_MAX - 1);

    // Source of an emitted byte
    typedef enum logic [1:0] {
        BSEL_RUN_HDR,
        BSEL_RUN_VAL,
        BSEL_LIT_HDR,
        BSEL_LIT_DATA
    } rbe_bsel_t;

    // Source of a byte appended to the literal buffer
    typedef enum logic [1:0] {
        LSRC_BYTE,
        LSRC_LA0,
        LSRC_LA1
    } rbe_lsrc_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      run_inc;
        logic      force_set;
        logic      force_clr;
        logic      run_start;
        logic      run_clear;
        logic      add_lit;
        rbe_lsrc_t lit_src;
        logic      la_shift;
        logic      la_push;
        logic      emit;
        rbe_bsel_t byte_sel;
        logic      flush_first;
        logic      flush_next;
        logic      lit_clr;
        logic      push_final;
        logic      frame_clr;
    } rbe_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       item_last;
        logic       in_run;
        logic       run_match;
        logic       run_full;
        logic       force_lit;
        logic [1:0] la_cnt;
        logic       triple;
        logic       lit_empty;
        logic       lit_fill;
        logic       flush_last;
        logic       emit_ok;
        logic       out_free;
        logic       pk_empty;
    } rbe_stat_t;

endpackage

// ===== rtl/rbe_if.sv =====
// Valid/ready channel interfaces for raw input bytes and packed output words.
interface rbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_last;

    modport source (output valid, output in_byte, output frame_last, input ready);
    modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

interface rbe_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic [2:0]  byte_count;
    logic        last_of_input;
    logic        frame_end;

    modport source (output valid, output out_word, output byte_count,
                    output last_of_input, output frame_end, input ready);
    modport sink   (input valid, input out_word, input byte_count,
                    input last_of_input, input frame_end, output ready);
endinterface

// ===== rtl/rbe_datapath.sv =====
// Encoder datapath: run and lookahead state, literal buffer memory, word packer, output register.
module rbe_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  rbe_pkg::rbe_cmd_t  cmd,
    output rbe_pkg::rbe_stat_t stat,
    input  logic [7:0]         in_byte,
    input  logic               frame_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_word,
    output logic [2:0]         byte_count,
    output logic               last_of_input,
    output logic               frame_end
);
    import rbe_pkg::*;

    logic [7:0]        item_byte_reg;
    logic              item_last_reg;
    logic [7:0]        la0_reg;
    logic [7:0]        la1_reg;
    logic [1:0]        la_cnt_reg;
    logic              in_run_reg;
    logic [7:0]        run_value_reg;
    logic [7:0]        run_length_reg;
    logic              force_reg;
    logic [LIT_CW-1:0] lit_count_reg;
    logic [7:0]        lit_mem [LIT_MAX];
    logic [7:0]        rd_data_reg;
    logic [LIT_AW-1:0] idx_reg;
    logic [LIT_AW-1:0] rd_addr;
    logic [7:0]        lit_wdata;
    logic [7:0]        emit_byte;
    logic [31:0]       pk_word_reg;
    logic [31:0]       pk_word_next;
    logic [2:0]        pk_cnt_reg;
    logic              pk_full;
    logic              push_word;
    logic              out_free;
    logic              out_valid_reg;
    logic [31:0]       out_word_reg;
    logic [2:0]        out_cnt_reg;
    logic              out_loi_reg;
    logic              out_fe_reg;

    // Item capture at accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_byte_reg <= in_byte;
            item_last_reg <= frame_last;
        end
    end

    // Run, force-literal and lookahead count state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg     <= 1'b0;
            run_value_reg  <= '0;
            run_length_reg <= '0;
            force_reg      <= 1'b0;
            la_cnt_reg     <= '0;
        end
        else if (cmd.frame_clr)
        begin
            in_run_reg     <= 1'b0;
            run_value_reg  <= '0;
            run_length_reg <= '0;
            force_reg      <= 1'b0;
            la_cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.run_start)
            begin
                in_run_reg     <= 1'b1;
                run_value_reg  <= la0_reg;
                run_length_reg <= RUN_START;
                la_cnt_reg     <= '0;
            end
            else if (cmd.run_clear)
            begin
                in_run_reg     <= 1'b0;
                run_length_reg <= '0;
            end
            else if (cmd.run_inc)
            begin
                run_length_reg <= run_length_reg + 8'd1;
            end

            if (cmd.la_push)
                la_cnt_reg <= la_cnt_reg + 2'd1;

            if (cmd.force_set)
                force_reg <= 1'b1;
            else if (cmd.force_clr)
                force_reg <= 1'b0;
        end
    end

    // Lookahead bytes
    always_ff @(posedge clk)
    begin
        if (cmd.la_push)
        begin
            if (la_cnt_reg[0])
                la1_reg <= item_byte_reg;
            else
                la0_reg <= item_byte_reg;
        end
        else if (cmd.la_shift)
        begin
            la0_reg <= la1_reg;
            la1_reg <= item_byte_reg;
        end
    end

    // Literal count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lit_count_reg <= '0;
        else if (cmd.lit_clr)
            lit_count_reg <= '0;
        else if (cmd.add_lit)
            lit_count_reg <= lit_count_reg + LIT_CW'(1);
    end

    // Literal write data select
    always_comb
    begin
        unique case (cmd.lit_src)
            LSRC_BYTE: lit_wdata = item_byte_reg;
            LSRC_LA0:  lit_wdata = la0_reg;
            LSRC_LA1:  lit_wdata = la1_reg;
            default:   lit_wdata = item_byte_reg;
        endcase
    end

    assign rd_addr = cmd.flush_first ? '0 : idx_reg + LIT_AW'(1);

    // Literal buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.add_lit)
            lit_mem[lit_count_reg[LIT_AW-1:0]] <= lit_wdata;
        if (cmd.flush_first || cmd.flush_next)
            rd_data_reg <= lit_mem[rd_addr];
    end

    // Flush read index
    always_ff @(posedge clk)
    begin
        if (cmd.flush_first)
            idx_reg <= '0;
        else if (cmd.flush_next)
            idx_reg <= idx_reg + LIT_AW'(1);
    end

    // Emitted byte select
    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_RUN_HDR:  emit_byte = run_length_reg + RUN_HDR_OFS;
            BSEL_RUN_VAL:  emit_byte = run_value_reg;
            BSEL_LIT_HDR:  emit_byte = 8'(lit_count_reg - LIT_CW'(1));
            BSEL_LIT_DATA: emit_byte = rd_data_reg;
            default:       emit_byte = rd_data_reg;
        endcase
    end

    // Word packer: a full word leaves only when a fifth byte arrives or the request ends
    assign pk_full   = (pk_cnt_reg == 3'd4);
    assign out_free  = !out_valid_reg || out_ready;
    assign push_word = (cmd.emit && pk_full) || cmd.push_final;

    always_comb
    begin
        pk_word_next = pk_word_reg;
        if (pk_full || pk_cnt_reg == 3'd0)
        begin
            pk_word_next = {24'd0, emit_byte};
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (pk_cnt_reg[1:0] == 2'(i))
                    pk_word_next[i*8 +: 8] = emit_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            pk_word_reg <= pk_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pk_cnt_reg <= '0;
        else if (cmd.emit)
            pk_cnt_reg <= pk_full ? 3'd1 : pk_cnt_reg + 3'd1;
        else if (cmd.push_final)
            pk_cnt_reg <= '0;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push_word)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push_word)
        begin
            out_word_reg <= pk_word_reg;
            out_cnt_reg  <= pk_cnt_reg;
            out_loi_reg  <= cmd.push_final;
            out_fe_reg   <= cmd.push_final && item_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_word      = out_word_reg;
    assign byte_count    = out_cnt_reg;
    assign last_of_input = out_loi_reg;
    assign frame_end     = out_fe_reg;

    // Status to controller
    always_comb
    begin
        stat.item_last  = item_last_reg;
        stat.in_run     = in_run_reg;
        stat.run_match  = (item_byte_reg == run_value_reg);
        stat.run_full   = (run_length_reg == RUN_LAST_INC);
        stat.force_lit  = force_reg;
        stat.la_cnt     = la_cnt_reg;
        stat.triple     = (la_cnt_reg == 2'd2) && (la0_reg == la1_reg)
                          && (la1_reg == item_byte_reg);
        stat.lit_empty  = (lit_count_reg == '0);
        stat.lit_fill   = (lit_count_reg == LIT_FILL_AT);
        stat.flush_last = (({1'b0, idx_reg} + LIT_CW'(1)) == lit_count_reg);
        stat.emit_ok    = !pk_full || out_free;
        stat.out_free   = out_free;
        stat.pk_empty   = (pk_cnt_reg == 3'd0);
    end

endmodule

// ===== rtl/rbe_ctrl.sv =====
// Encoder controller: sequences classification, run and literal block output for each request.
module rbe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output rbe_pkg::rbe_cmd_t  cmd,
    input  rbe_pkg::rbe_stat_t stat
);
    import rbe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RUN_HDR,
        S_RUN_VAL,
        S_ADD_B,
        S_END_CHECK,
        S_END_LA0,
        S_END_LA1,
        S_FLUSH_HDR,
        S_FLUSH_LIT,
        S_STEP_END
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t ret_reg;
    state_t ret_next;
    state_t done_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        done_st    = stat.item_last ? S_END_CHECK : S_IDLE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end

            // Classify the new byte
            S_DECIDE:
            begin
                if (stat.in_run)
                begin
                    if (stat.run_match)
                    begin
                        cmd.run_inc = 1'b1;
                        if (stat.run_full)
                        begin
                            cmd.force_set = 1'b1;
                            ret_next      = S_END_CHECK;
                            state_next    = S_RUN_HDR;
                        end
                        else
                        begin
                            state_next = done_st;
                        end
                    end
                    else
                    begin
                        ret_next   = S_ADD_B;
                        state_next = S_RUN_HDR;
                    end
                end
                else if (stat.force_lit)
                begin
                    cmd.force_clr = 1'b1;
                    cmd.add_lit   = 1'b1;
                    cmd.lit_src   = LSRC_BYTE;
                    if (stat.lit_fill)
                    begin
                        ret_next   = S_END_CHECK;
                        state_next = S_FLUSH_HDR;
                    end
                    else
                    begin
                        state_next = done_st;
                    end
                end
                else if (stat.la_cnt == 2'd2)
                begin
                    if (stat.triple)
                    begin
                        cmd.run_start = 1'b1;
                        ret_next      = S_END_CHECK;
                        state_next    = S_FLUSH_HDR;
                    end
                    else
                    begin
                        cmd.add_lit  = 1'b1;
                        cmd.lit_src  = LSRC_LA0;
                        cmd.la_shift = 1'b1;
                        if (stat.lit_fill)
                        begin
                            ret_next   = S_END_CHECK;
                            state_next = S_FLUSH_HDR;
                        end
                        else
                        begin
                            state_next = done_st;
                        end
                    end
                end
                else
                begin
                    cmd.la_push = 1'b1;
                    state_next  = done_st;
                end
            end

            // Run block: header then value
            S_RUN_HDR:
            begin
                cmd.byte_sel = BSEL_RUN_HDR;
                if (stat.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_RUN_VAL;
                end
            end

            S_RUN_VAL:
            begin
                cmd.byte_sel = BSEL_RUN_VAL;
                if (stat.emit_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.run_clear = 1'b1;
                    state_next    = ret_reg;
                end
            end

            // Byte that broke a run becomes a literal
            S_ADD_B:
            begin
                cmd.add_lit = 1'b1;
                cmd.lit_src = LSRC_BYTE;
                ret_next    = S_END_CHECK;
                state_next  = stat.lit_fill ? S_FLUSH_HDR : S_END_CHECK;
            end

            // Request end: on a frame's last byte close run, drain lookahead, flush literals
            S_END_CHECK:
            begin
                if (!stat.item_last)
                begin
                    state_next = S_STEP_END;
                end
                else if (stat.in_run)
                begin
                    ret_next   = S_END_LA0;
                    state_next = S_RUN_HDR;
                end
                else
                begin
                    state_next = S_END_LA0;
                end
            end

            S_END_LA0:
            begin
                if (stat.la_cnt != 2'd0)
                begin
                    cmd.add_lit = 1'b1;
                    cmd.lit_src = LSRC_LA0;
                    ret_next    = S_END_LA1;
                    state_next  = stat.lit_fill ? S_FLUSH_HDR : S_END_LA1;
                end
                else
                begin
                    ret_next   = S_STEP_END;
                    state_next = S_FLUSH_HDR;
                end
            end

            S_END_LA1:
            begin
                if (stat.la_cnt == 2'd2)
                begin
                    cmd.add_lit = 1'b1;
                    cmd.lit_src = LSRC_LA1;
                end
                ret_next   = S_STEP_END;
                state_next = S_FLUSH_HDR;
            end

            // Literal block: header then buffered bytes
            S_FLUSH_HDR:
            begin
                cmd.byte_sel = BSEL_LIT_HDR;
                if (stat.lit_empty)
                begin
                    state_next = ret_reg;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.flush_first = 1'b1;
                    state_next      = S_FLUSH_LIT;
                end
            end

            S_FLUSH_LIT:
            begin
                cmd.byte_sel = BSEL_LIT_DATA;
                if (stat.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    if (stat.flush_last)
                    begin
                        cmd.lit_clr = 1'b1;
                        state_next  = ret_reg;
                    end
                    else
                    begin
                        cmd.flush_next = 1'b1;
                    end
                end
            end

            // Send the partial word that closes this request
            S_STEP_END:
            begin
                if (stat.pk_empty)
                begin
                    cmd.frame_clr = stat.item_last;
                    state_next    = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.push_final = 1'b1;
                    cmd.frame_clr  = stat.item_last;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rle_byte_stream_encoder.sv =====
// Top level of the run-length byte stream encoder.
//
// src_bytes carries one raw byte per request, with frame_last on the final
// byte of a frame. enc_words carries the encoded stream packed into 32-bit
// words, first byte in bits 7:0, byte_count valid bytes; last_of_input marks
// the final word caused by one input byte, frame_end the final word of a frame.
// An input byte that produces no word is only accepted and classified.
// A byte that sends blocks also steps through the run and literal block states;
// buffered literal bytes leave the literal buffer one per cycle while enc_words
// does not stall, through its single registered read port; a full literal block is 65 bytes.
// A word enters the output register once the request's fifth encoded byte is
// produced, and the closing word after the request's last encoded byte.
// src_bytes is ready only between requests.
// Reset clears the run, lookahead and literal counts and the output register;
// the literal buffer needs no clearing. When enc_words stalls, the encoder
// holds at the next encoded byte once a full word waits in the packer, and at
// the end of the request, until the output register frees up.
module rle_byte_stream_encoder (
    input  logic     clk,
    input  logic     rst_n,
    rbe_in_if.sink   src_bytes,
    rbe_out_if.source enc_words
);
    import rbe_pkg::*;

    rbe_cmd_t  cmd;
    rbe_stat_t stat;
    logic      ready;

    rbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (src_bytes.valid),
        .in_ready (ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rbe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_byte       (src_bytes.in_byte),
        .frame_last    (src_bytes.frame_last),
        .out_valid     (enc_words.valid),
        .out_ready     (enc_words.ready),
        .out_word      (enc_words.out_word),
        .byte_count    (enc_words.byte_count),
        .last_of_input (enc_words.last_of_input),
        .frame_end     (enc_words.frame_end)
    );

    assign src_bytes.ready = ready;

endmodule
